### hw/rtl/irc_pkg.sv
package irc_pkg;

  // configuration register map
  localparam int unsigned NUM_COEF_REGS = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAN0 = 3'd0,
    REG_CHAN1 = 3'd1,
    REG_CHAN2 = 3'd2,
    REG_CHAN3 = 3'd3,
    REG_MASK  = 3'd4
  } reg_idx_t;

  localparam logic [3:0] MASK_RESET = 4'd3;

  // fixed-point constants
  localparam logic signed [12:0] TREF_SIXTEENTHS = 13'sd352;
  localparam logic signed [51:0] LOG2_TEN_Q28    = 52'sd891723283;
  localparam logic [31:0] EXP_C0 = 32'd1073741824;
  localparam logic [31:0] EXP_C1 = 32'd747394792;
  localparam logic [31:0] EXP_C2 = 32'd241048959;
  localparam logic [26:0] EXP_C3 = 27'd85298306;
  localparam logic signed [43:0] X_HI = 44'sd655360;
  localparam logic signed [43:0] X_LO = -44'sd524288;
  localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;

  // coefficients of the selected channel
  typedef struct packed {
    logic signed [31:0] scl;
    logic signed [15:0] ofs;
    logic signed [15:0] tc;
    logic               ph;
  } coef_t;

  // payload carried alongside the arithmetic
  typedef struct packed {
    logic [11:0]        raw;
    logic [15:0]        sense;
    logic               present;
    logic               ph;
    logic signed [43:0] lin;
    logic               big;
    logic               small_x;
  } side_t;

endpackage

### hw/rtl/irc_if.sv
interface irc_in_if #(parameter int ADC_BITS = 12);
  logic                valid;
  logic                ready;
  logic [1:0]          channel;
  logic [ADC_BITS-1:0] sample_code;
  logic signed [11:0]  temperature;

  modport source (output valid, channel, sample_code, temperature, input ready);
  modport sink   (input valid, channel, sample_code, temperature, output ready);
endinterface

interface irc_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        raw_count;
  logic [15:0]        sense_voltage;
  logic signed [47:0] concentration;
  logic               saturated;

  modport source (output valid, raw_count, sense_voltage, concentration, saturated,
                  input ready);
  modport sink   (input valid, raw_count, sense_voltage, concentration, saturated,
                  output ready);
endinterface

### hw/rtl/irc_cfg.sv
module irc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [irc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [irc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [1:0]                          channel,
  output irc_pkg::coef_t                      coef
);

  logic [63:0] coefs [irc_pkg::NUM_COEF_REGS];
  logic [3:0]  mask;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < irc_pkg::NUM_COEF_REGS; i++) coefs[i] <= '0;
      mask <= irc_pkg::MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        irc_pkg::REG_CHAN0, irc_pkg::REG_CHAN1, irc_pkg::REG_CHAN2,
        irc_pkg::REG_CHAN3: coefs[cfg_index[1:0]] <= cfg_wdata;
        irc_pkg::REG_MASK:  mask <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // channel select and field unpack
  always_comb begin
    coef.tc  = coefs[channel][15:0];
    coef.ofs = coefs[channel][31:16];
    coef.scl = coefs[channel][63:32];
    coef.ph  = mask[channel];
  end

endmodule

### hw/rtl/isfet_reading_conversion_top.sv
// an input transfer is registered in each stage in turn; the last stage is the output register
// throughput: one item per cycle while out_ch.ready is high; the stage chain holds up to 9 items
// each stage advances independently, so bubbles close up behind a stalled output
// rst (synchronous) clears stage valids, coefficients to 0 and the ph mask to 3
module isfet_reading_conversion_top #(
  parameter int NUM_CHANNELS = 4,
  parameter int ADC_BITS     = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  irc_in_if.sink                         in_ch,
  irc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [irc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NS = 9;

  logic [NS:1]   v;
  logic [NS+1:1] rdy;

  irc_pkg::coef_t sel;

  irc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .channel   (in_ch.channel),
    .coef      (sel)
  );

  // per-stage ready: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NS+1] = out_ch.ready;
    for (int k = NS; k >= 1; k--) rdy[k] = ~v[k] | rdy[k+1];
  end

  assign in_ch.ready  = rdy[1];
  assign out_ch.valid = v[NS];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_ch.valid;
      for (int k = 2; k <= NS; k++) if (rdy[k]) v[k] <= v[k-1];
    end
  end

  // stage 1: voltage, temperature term, coefficient capture
  logic [ADC_BITS+11:0] cnt_mv;
  logic [27:0]          v16_in;
  logic signed [12:0]   dt_in;
  logic signed [28:0]   tterm_in;
  irc_pkg::side_t       side_in;

  always_comb begin
    cnt_mv   = (ADC_BITS+12)'(in_ch.sample_code) * (ADC_BITS+12)'(2500);
    v16_in   = 28'(cnt_mv) << (16 - ADC_BITS);
    dt_in    = {in_ch.temperature[11], in_ch.temperature} - irc_pkg::TREF_SIXTEENTHS;
    tterm_in = 29'(sel.tc) * 29'(dt_in);
    side_in.raw     = 12'(in_ch.sample_code);
    side_in.sense   = v16_in[27:12];
    side_in.present = (int'(in_ch.channel) < NUM_CHANNELS);
    side_in.ph      = sel.ph;
    side_in.lin     = '0;
    side_in.big     = 1'b0;
    side_in.small_x = 1'b0;
  end

  irc_pkg::side_t     s1_side;
  logic [27:0]        s1_v16;
  logic signed [28:0] s1_tterm;
  logic signed [15:0] s1_ofs;
  logic signed [31:0] s1_scl;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_side  <= side_in;
      s1_v16   <= v16_in;
      s1_tterm <= tterm_in;
      s1_ofs   <= sel.ofs;
      s1_scl   <= sel.scl;
    end
  end

  // stage 2: calibrated sum in Q.16 mV
  irc_pkg::side_t     s2_side;
  logic signed [35:0] s2_sum;
  logic signed [31:0] s2_scl;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_side <= s1_side;
      s2_sum  <= $signed({8'd0, s1_v16}) - (36'(s1_tterm) <<< 4) + (36'(s1_ofs) <<< 12);
      s2_scl  <= s1_scl;
    end
  end

  // stage 3: scale times sum as two partial products
  irc_pkg::side_t     s3_side;
  logic signed [50:0] s3_plo;
  logic signed [49:0] s3_phi;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_side <= s2_side;
      s3_plo  <= 51'(s2_scl) * 51'($signed({1'b0, s2_sum[17:0]}));
      s3_phi  <= 50'(s2_scl) * 50'($signed(s2_sum[35:18]));
    end
  end

  // stage 4: combine, round to Q.16, range flags for the exponent
  logic signed [67:0] prod;
  logic signed [67:0] prod_rnd;
  logic signed [43:0] x_c;
  irc_pkg::side_t     side4_c;

  always_comb begin
    prod     = (68'(s3_phi) <<< 18) + 68'(s3_plo);
    prod_rnd = prod + 68'sh80_0000;
    x_c      = prod_rnd[67:24];
    side4_c         = s3_side;
    side4_c.lin     = x_c;
    side4_c.big     = (x_c > irc_pkg::X_HI);
    side4_c.small_x = (x_c < irc_pkg::X_LO);
  end

  irc_pkg::side_t s4_side;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_side <= side4_c;
    end
  end

  // stage 5: exponent to base two
  irc_pkg::side_t     s5_side;
  logic signed [51:0] s5_ym;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_side <= s4_side;
      s5_ym   <= 52'($signed(s4_side.lin[21:0])) * irc_pkg::LOG2_TEN_Q28;
    end
  end

  // stage 6: split into integer and fraction, first horner product
  logic signed [51:0] ym_rnd;
  logic [15:0]        f_c;

  always_comb begin
    ym_rnd = s5_ym + 52'sh800_0000;
    f_c    = ym_rnd[43:28];
  end

  irc_pkg::side_t    s6_side;
  logic signed [7:0] s6_n;
  logic [15:0]       s6_f;
  logic [42:0]       s6_q;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_side <= s5_side;
      s6_n    <= ym_rnd[51:44];
      s6_f    <= f_c;
      s6_q    <= 43'(irc_pkg::EXP_C3) * 43'(f_c);
    end
  end

  // stage 7: second horner step
  logic [31:0] p1;
  assign p1 = irc_pkg::EXP_C2 + 32'(s6_q[42:16]);

  irc_pkg::side_t    s7_side;
  logic signed [7:0] s7_n;
  logic [15:0]       s7_f;
  logic [47:0]       s7_q;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_side <= s6_side;
      s7_n    <= s6_n;
      s7_f    <= s6_f;
      s7_q    <= 48'(p1) * 48'(s6_f);
    end
  end

  // stage 8: third horner step
  logic [31:0] p2;
  assign p2 = irc_pkg::EXP_C1 + s7_q[47:16];

  irc_pkg::side_t    s8_side;
  logic signed [7:0] s8_n;
  logic [47:0]       s8_q;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_side <= s7_side;
      s8_n    <= s7_n;
      s8_q    <= 48'(p2) * 48'(s7_f);
    end
  end

  // stage 9: power-of-two shift, clipping and result select
  logic [31:0]        p3;
  logic [51:0]        r;
  logic [4:0]         shl;
  logic [5:0]         shr;
  logic signed [47:0] conc_c;
  logic               sat_c;

  always_comb begin
    p3  = irc_pkg::EXP_C0 + s8_q[47:16];
    shl = 5'(s8_n - 8'sd14);
    shr = 6'(8'sd14 - s8_n);
    if (s8_n >= 8'sd14) r = 52'(p3) << shl;
    else                r = (52'(p3) + (52'd1 << (shr - 6'd1))) >> shr;

    conc_c = '0;
    sat_c  = 1'b0;
    if (!s8_side.present) begin
      conc_c = '0;
    end else if (s8_side.ph) begin
      conc_c = 48'(s8_side.lin);
    end else if (s8_side.big) begin
      conc_c = irc_pkg::OUT_MAX;
      sat_c  = 1'b1;
    end else if (s8_side.small_x) begin
      conc_c = '0;
    end else if (r > 52'(irc_pkg::OUT_MAX)) begin
      conc_c = irc_pkg::OUT_MAX;
      sat_c  = 1'b1;
    end else begin
      conc_c = 48'(r);
    end
  end

  logic s9_lin;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      out_ch.raw_count     <= s8_side.raw;
      out_ch.sense_voltage <= s8_side.sense;
      out_ch.concentration <= conc_c;
      out_ch.saturated     <= sat_c;
      s9_lin               <= s8_side.present & s8_side.ph;
    end
  end

`ifndef SYNTHESIS
  // a clip always lands on the upper bound
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.saturated |-> out_ch.concentration == irc_pkg::OUT_MAX)
    else $error("saturated result not at bound");

  // linear results never clip
  a_lin_nosat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && s9_lin |-> !out_ch.saturated)
    else $error("linear channel flagged saturated");

  // an accepted item occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> v[1])
    else $error("input transfer lost");
`endif

endmodule
